### hw/rtl/spc_pkg.sv
// Shared types and constants of the sprite pixel collision block.
package spc_pkg;

  localparam int unsigned CmdBits     = 2;
  localparam int unsigned IdxBits     = 12;
  localparam int unsigned AlphaBits   = 8;
  localparam int unsigned CoordBits   = 13;
  localparam int unsigned EdgeBits    = 14;
  localparam int unsigned DimBits     = 7;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned MaskDepth   = 4096;
  localparam int unsigned MaxSide     = 64;
  localparam int unsigned DivBits     = 14;
  localparam int unsigned DivCntBits  = 4;

  typedef logic [CmdBits-1:0]          cmd_t;
  typedef logic [DimBits-1:0]          dim_t;
  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [EdgeBits-1:0]  edge_t;

  localparam cmd_t CmdLoadFirst  = 2'd0;
  localparam cmd_t CmdLoadSecond = 2'd1;
  localparam cmd_t CmdQuery      = 2'd2;

  localparam logic [1:0] OutcomeNone      = 2'd0;
  localparam logic [1:0] OutcomeIntersect = 2'd1;
  localparam logic [1:0] OutcomeCollision = 2'd2;

  localparam logic [CfgIdxBits-1:0] RegRenderedWidth   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegRenderedHeight  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegFirstRawWidth   = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegFirstRawHeight  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegSecondRawWidth  = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegSecondRawHeight = 3'd5;

  localparam dim_t DimReset = 7'd32;

  // A zero register is used as one, anything above the largest side as that side.
  function automatic dim_t dim_clamp(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > dim_t'(MaxSide)) r = dim_t'(MaxSide);
    return r;
  endfunction

endpackage

### hw/rtl/spc_in_if.sv
// Input channel of the sprite pixel collision block.
interface spc_in_if;
  logic                 valid;
  logic                 ready;
  spc_pkg::cmd_t        cmd;
  logic [11:0]          texel_index;
  logic [7:0]           texel_alpha;
  spc_pkg::coord_t      first_left;
  spc_pkg::coord_t      first_top;
  spc_pkg::coord_t      second_left;
  spc_pkg::coord_t      second_top;

  modport source (output valid, cmd, texel_index, texel_alpha, first_left, first_top,
                  second_left, second_top, input ready);
  modport sink   (input valid, cmd, texel_index, texel_alpha, first_left, first_top,
                  second_left, second_top, output ready);
endinterface

### hw/rtl/spc_out_if.sv
// Result channel of the sprite pixel collision block.
interface spc_out_if;
  logic            valid;
  logic            ready;
  logic [1:0]      outcome;
  spc_pkg::edge_t  overlap_left;
  spc_pkg::edge_t  overlap_right;
  spc_pkg::edge_t  overlap_top;
  spc_pkg::edge_t  overlap_bottom;

  modport source (output valid, outcome, overlap_left, overlap_right, overlap_top,
                  overlap_bottom, input ready);
  modport sink   (input valid, outcome, overlap_left, overlap_right, overlap_top,
                  overlap_bottom, output ready);
endinterface

### hw/rtl/sprite_pixel_collision_top.sv
// Top level of the sprite pixel collision block: opacity masks, divider and scanner.
//
// Usage: the input channel carries loads and queries. A load (cmd 0 or 1) writes one
// bit of the moving or obstacle opacity mask and gives no result transfer. A query
// (cmd 2) gives exactly one result transfer with the outcome and the intersection
// rectangle. Command 3 is dropped without a result.
// A query whose sprites do not meet goes straight to its result; else eight runs
// of a shared restoring divider find the texel start points and step sizes, and then
// the overlap pixels are scanned through a registered read of each mask memory. The
// scan stops at the first pixel opaque in both masks. The single read port of each
// mask memory sets the pixel rate of one per cycle.
// Only one query is worked on at a time. A finished result sits in an output
// register, and loads and a new query are still accepted while it waits; a second
// query result waits in its final state until the receiver takes the first.
// Reset clears the control state and sets all six dimension registers to 32; the mask
// memories are not cleared and must be written before they are read.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// do so only while idle, as the block itself does not enforce it.
module sprite_pixel_collision_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [spc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  spc_pkg::dim_t                  cfg_data_i,
  spc_in_if.sink                         in_i,
  spc_out_if.source                      out_o
);
  import spc_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StDiv  = 4'b0010,
    StScan = 4'b0100,
    StDone = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Dimension registers.
  dim_t rw_raw_q, rh_raw_q, fw_raw_q, fh_raw_q, sw_raw_q, sh_raw_q;
  dim_t rw, rh;
  dim_t dimv [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_raw_q <= DimReset; rh_raw_q <= DimReset;
      fw_raw_q <= DimReset; fh_raw_q <= DimReset;
      sw_raw_q <= DimReset; sh_raw_q <= DimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegRenderedWidth:   rw_raw_q <= cfg_data_i;
        RegRenderedHeight:  rh_raw_q <= cfg_data_i;
        RegFirstRawWidth:   fw_raw_q <= cfg_data_i;
        RegFirstRawHeight:  fh_raw_q <= cfg_data_i;
        RegSecondRawWidth:  sw_raw_q <= cfg_data_i;
        RegSecondRawHeight: sh_raw_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign rw = dim_clamp(rw_raw_q);
  assign rh = dim_clamp(rh_raw_q);
  // Axis k: 0 moving x, 1 moving y, 2 obstacle x, 3 obstacle y.
  assign dimv[0] = dim_clamp(fw_raw_q);
  assign dimv[1] = dim_clamp(fh_raw_q);
  assign dimv[2] = dim_clamp(sw_raw_q);
  assign dimv[3] = dim_clamp(sh_raw_q);

  // Query geometry, worked out at the transfer of the query.
  edge_t fl, ft, sl, st, fr, fb, sr, sb, left, right, top, bottom;
  logic  meet;

  assign fl = EdgeBits'(in_i.first_left);
  assign ft = EdgeBits'(in_i.first_top);
  assign sl = EdgeBits'(in_i.second_left);
  assign st = EdgeBits'(in_i.second_top);
  assign fr = fl + edge_t'({7'd0, rw});
  assign sr = sl + edge_t'({7'd0, rw});
  assign fb = ft + edge_t'({7'd0, rh});
  assign sb = st + edge_t'({7'd0, rh});
  assign left   = (fl > sl) ? fl : sl;
  assign right  = (fr < sr) ? fr : sr;
  assign top    = (ft > st) ? ft : st;
  assign bottom = (fb < sb) ? fb : sb;
  // Touching edges still meet: the rectangle is then empty.
  assign meet = (left <= right) && (top <= bottom);

  logic in_xfer, is_query, load_first, load_second;
  assign in_i.ready  = (state_q == StIdle);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign is_query    = in_xfer && (in_i.cmd == CmdQuery);
  assign load_first  = in_xfer && (in_i.cmd == CmdLoadFirst);
  assign load_second = in_xfer && (in_i.cmd == CmdLoadSecond);

  edge_t      rect_l_q, rect_r_q, rect_t_q, rect_b_q;
  logic [1:0] outcome_q;
  dim_t       w_q, h_q;
  dim_t       off_q [4];

  // Shared restoring divider. Jobs 0..3 give the per-pixel step dim/rendered of each
  // axis, jobs 4..7 the start point offset*dim/rendered of each axis.
  logic [2:0]            job_q;
  logic [DivCntBits-1:0] div_cnt_q;
  logic [DivBits-1:0]    quo_q, quo_nx, dividend;
  dim_t                  drem_q, drem_nx, divisor, mul_a;
  logic [DimBits:0]      trial;
  logic                  ge;

  assign mul_a    = job_q[2] ? off_q[job_q[1:0]] : 7'd1;
  assign dividend = {7'd0, mul_a} * {7'd0, dimv[job_q[1:0]]};
  assign divisor  = job_q[0] ? rh : rw;
  assign trial    = {drem_q, quo_q[DivBits-1]};
  assign ge       = trial >= {1'b0, divisor};
  assign drem_nx  = ge ? DimBits'(trial - {1'b0, divisor}) : DimBits'(trial);
  assign quo_nx   = {quo_q[DivBits-2:0], ge};

  dim_t step_q [4];
  dim_t srem_q [4];
  dim_t start_q [4];
  dim_t strem_q [4];

  // Scan state: texel coordinate and remainder of each axis.
  dim_t pos_q [4];
  dim_t rem_q [4];
  dim_t pos_nx [4];
  dim_t rem_nx [4];
  dim_t col_q, row_q;
  logic issued_all_q, col_wrap, last_px;

  for (genvar k = 0; k < 4; k++) begin : g_axis
    logic [DimBits:0] rsum;
    dim_t             dv;
    assign dv        = (k % 2 == 1) ? rh : rw;
    assign rsum      = {1'b0, rem_q[k]} + {1'b0, srem_q[k]};
    assign pos_nx[k] = (rsum >= {1'b0, dv}) ? pos_q[k] + step_q[k] + 7'd1
                                            : pos_q[k] + step_q[k];
    assign rem_nx[k] = (rsum >= {1'b0, dv}) ? DimBits'(rsum - {1'b0, dv})
                                            : DimBits'(rsum);
  end

  assign col_wrap = (col_q == w_q - 7'd1);
  assign last_px  = col_wrap && (row_q == h_q - 7'd1);

  // Texel addresses of the current pixel in both masks.
  logic [13:0] idx_f, idx_s;
  logic        issue;
  assign idx_f = ({7'd0, pos_q[1]} * {7'd0, dimv[0]}) + {7'd0, pos_q[0]};
  assign idx_s = ({7'd0, pos_q[3]} * {7'd0, dimv[2]}) + {7'd0, pos_q[2]};
  assign issue = (state_q == StScan) && !issued_all_q;

  // Mask memories.
  logic mem_f [MaskDepth];
  logic mem_s [MaskDepth];
  logic bit_f_q, bit_s_q;

  always_ff @(posedge clk_i) begin
    if (load_first) mem_f[in_i.texel_index] <= (in_i.texel_alpha != '0);
    bit_f_q <= mem_f[idx_f[IdxBits-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (load_second) mem_s[in_i.texel_index] <= (in_i.texel_alpha != '0);
    bit_s_q <= mem_s[idx_s[IdxBits-1:0]];
  end

  logic rd_vld_q, rd_last_q, rd_oob_q, hit;
  assign hit = rd_vld_q && !rd_oob_q && bit_f_q && bit_s_q;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (is_query) state_d = meet ? StDiv : StDone;
      StDiv: begin
        if (div_cnt_q == DivCntBits'(DivBits) && job_q == 3'd7) begin
          state_d = ((w_q == '0) || (h_q == '0)) ? StDone : StScan;
        end
      end
      StScan: if (hit || (rd_vld_q && rd_last_q)) state_d = StDone;
      StDone: if (!out_o.valid || out_o.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      job_q        <= '0;
      div_cnt_q    <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      outcome_q    <= OutcomeNone;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= issue;
      if (is_query) begin
        outcome_q <= meet ? OutcomeIntersect : OutcomeNone;
        job_q     <= '0;
        div_cnt_q <= '0;
      end
      if (state_q == StDiv) begin
        if (div_cnt_q == DivCntBits'(DivBits)) begin
          div_cnt_q <= '0;
          job_q     <= job_q + 3'd1;
        end else begin
          div_cnt_q <= div_cnt_q + DivCntBits'(1);
        end
      end
      if (state_q == StDiv) issued_all_q <= 1'b0;
      else if (issue && last_px) issued_all_q <= 1'b1;
      if (hit) outcome_q <= OutcomeCollision;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (is_query) begin
      rect_l_q <= meet ? left : '0;
      rect_r_q <= meet ? right : '0;
      rect_t_q <= meet ? top : '0;
      rect_b_q <= meet ? bottom : '0;
      w_q      <= DimBits'(right - left);
      h_q      <= DimBits'(bottom - top);
      off_q[0] <= DimBits'(left - fl);
      off_q[1] <= DimBits'(top - ft);
      off_q[2] <= DimBits'(left - sl);
      off_q[3] <= DimBits'(top - st);
    end
    if (state_q == StDiv) begin
      if (div_cnt_q == '0) begin
        quo_q  <= dividend;
        drem_q <= '0;
      end else begin
        quo_q  <= quo_nx;
        drem_q <= drem_nx;
        if (div_cnt_q == DivCntBits'(DivBits)) begin
          if (job_q[2]) begin
            start_q[job_q[1:0]] <= DimBits'(quo_nx);
            strem_q[job_q[1:0]] <= drem_nx;
          end else begin
            step_q[job_q[1:0]] <= DimBits'(quo_nx);
            srem_q[job_q[1:0]] <= drem_nx;
          end
        end
      end
      col_q <= '0;
      row_q <= '0;
      // A start point finished in this cycle is taken straight from the divider.
      for (int k = 0; k < 4; k++) begin
        if (job_q == {1'b1, 2'(k)} && div_cnt_q == DivCntBits'(DivBits)) begin
          pos_q[k] <= DimBits'(quo_nx);
          rem_q[k] <= drem_nx;
        end else begin
          pos_q[k] <= start_q[k];
          rem_q[k] <= strem_q[k];
        end
      end
    end
    if (issue) begin
      rd_last_q <= last_px;
      rd_oob_q  <= (idx_f >= 14'(MaskDepth)) || (idx_s >= 14'(MaskDepth));
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_q + 7'd1;
        for (int k = 0; k < 4; k += 2) begin
          pos_q[k]   <= start_q[k];
          rem_q[k]   <= strem_q[k];
          pos_q[k+1] <= pos_nx[k+1];
          rem_q[k+1] <= rem_nx[k+1];
        end
      end else begin
        col_q <= col_q + 7'd1;
        for (int k = 0; k < 4; k += 2) begin
          pos_q[k] <= pos_nx[k];
          rem_q[k] <= rem_nx[k];
        end
      end
    end
  end

  // Output register.
  logic out_vld_q;
  logic load_out;
  assign load_out = (state_q == StDone) && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (load_out) out_vld_q <= 1'b1;
    else if (out_o.ready) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_o.outcome        <= outcome_q;
      out_o.overlap_left   <= rect_l_q;
      out_o.overlap_right  <= rect_r_q;
      out_o.overlap_top    <= rect_t_q;
      out_o.overlap_bottom <= rect_b_q;
    end
  end

  assign out_o.valid = out_vld_q;

`ifndef ASSERT_OFF
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (w_q != '0) && (h_q != '0))
    else $error("scan with an empty rectangle");
  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == StScan))
    else $error("mask read outside the scan");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q <= DivCntBits'(DivBits))
    else $error("divider count out of range");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && outcome_q == OutcomeNone) |-> (rect_l_q == '0) && (rect_r_q == '0))
    else $error("no-overlap result with nonzero edges");
`endif

endmodule

### test/sprite_pixel_collision_top_tb.sv
// Self-checking testbench of the sprite pixel collision block.
`timescale 1ns / 100ps

module sprite_pixel_collision_top_tb;
  import spc_pkg::*;

  // One input item as the sender offers it.
  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] texel_index;
    logic [7:0]  texel_alpha;
    coord_t      first_left;
    coord_t      first_top;
    coord_t      second_left;
    coord_t      second_top;
  } item_t;

  // One result as the receiver sees it.
  typedef struct packed {
    logic [1:0] outcome;
    edge_t      left;
    edge_t      right;
    edge_t      top;
    edge_t      bottom;
  } rect_t;

  // A row of the directed table: an item and, where obvious, its typed result.
  typedef struct {
    item_t it;
    bit    typed;
    rect_t res;
  } row_t;

  localparam int unsigned StallPct    = 27;
  localparam int unsigned WatchLimit  = 20000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned SettleCyc   = 20;
  localparam int unsigned FillTexels  = 32;
  localparam int unsigned PhaseItems  = 9;
  localparam logic [CfgIdxBits-1:0] RegBeyond6 = 3'd6;
  localparam logic [CfgIdxBits-1:0] RegBeyond7 = 3'd7;
  localparam cmd_t CmdUnused = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxBits-1:0] cfg_idx_i;
  dim_t cfg_data_i;

  spc_in_if  in_ch ();
  spc_out_if out_ch ();

  sprite_pixel_collision_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // Local copy of the block's state, kept in step with each accepted transfer.
  dim_t dims [6];
  bit   moving_opaque   [MaskDepth];
  bit   obstacle_opaque [MaskDepth];
  rect_t pending_rects[$];

  int unsigned errors = 0;
  int unsigned queries_sent;
  int unsigned collisions_seen = 0;
  int unsigned results_seen = 0;
  bit          hold_req = 1'b0;
  bit          hold_done_q;
  int unsigned hold_cnt_q;
  bit          send_gaps;
  bit          recv_gaps;
  int unsigned quiet_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int side_of(input dim_t v);
    if (v == 0) return 1;
    if (v > MaxSide) return MaxSide;
    return v;
  endfunction

  function automatic bit spans_meet(input int a0, input int a1, input int b0, input int b1);
    if (a0 <= b0 && a1 < b0) return 1'b0;
    if (b0 <= a0 && b1 < a0) return 1'b0;
    return 1'b1;
  endfunction

  // Works out the rectangle and outcome of a query from the local masks and sizes.
  function automatic rect_t overlap_of(input item_t it);
    rect_t r;
    int rw, rh, fw, fh, sw, sh;
    int fl, ft, sl, st, left, right, top, bottom;
    int fx, fy, sx, sy, fidx, sidx;
    bit hit;
    rw = side_of(dims[0]); rh = side_of(dims[1]);
    fw = side_of(dims[2]); fh = side_of(dims[3]);
    sw = side_of(dims[4]); sh = side_of(dims[5]);
    fl = it.first_left;  ft = it.first_top;
    sl = it.second_left; st = it.second_top;
    r = '0;
    if (!spans_meet(fl, fl + rw, sl, sl + rw) || !spans_meet(ft, ft + rh, st, st + rh)) begin
      r.outcome = OutcomeNone;
      return r;
    end
    left   = (fl > sl) ? fl : sl;
    right  = (fl + rw < sl + rw) ? fl + rw : sl + rw;
    top    = (ft > st) ? ft : st;
    bottom = (ft + rh < st + rh) ? ft + rh : st + rh;
    hit = 1'b0;
    for (int y = top; y < bottom && !hit; y++) begin
      for (int x = left; x < right && !hit; x++) begin
        fx = (x - fl) * fw / rw;  fy = (y - ft) * fh / rh;
        sx = (x - sl) * sw / rw;  sy = (y - st) * sh / rh;
        fidx = fy * fw + fx;
        sidx = sy * sw + sx;
        if (fidx < MaskDepth && sidx < MaskDepth)
          hit = moving_opaque[fidx] && obstacle_opaque[sidx];
      end
    end
    r.outcome = hit ? OutcomeCollision : OutcomeIntersect;
    r.left    = edge_t'(left);
    r.right   = edge_t'(right);
    r.top     = edge_t'(top);
    r.bottom  = edge_t'(bottom);
    return r;
  endfunction

  // An item with every field random.
  function automatic item_t noise_item();
    logic [95:0] rnd;
    rnd = {$urandom, $urandom, $urandom};
    return item_t'(rnd[$bits(item_t)-1:0]);
  endfunction

  // Offers one item, waits for its transfer, then updates the local state.
  task automatic offer_item(input item_t it, input bit typed, input rect_t res);
    while (send_gaps && $urandom_range(99) < StallPct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= it.cmd;
    in_ch.texel_index <= it.texel_index;
    in_ch.texel_alpha <= it.texel_alpha;
    in_ch.first_left  <= it.first_left;
    in_ch.first_top   <= it.first_top;
    in_ch.second_left <= it.second_left;
    in_ch.second_top  <= it.second_top;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    case (it.cmd)
      CmdLoadFirst:  moving_opaque[it.texel_index]   = (it.texel_alpha != 0);
      CmdLoadSecond: obstacle_opaque[it.texel_index] = (it.texel_alpha != 0);
      CmdQuery: begin
        pending_rects.push_back(typed ? res : overlap_of(it));
        queries_sent++;
      end
      default: ;
    endcase
  endtask

  // Lowers valid and waits until every result has come and the block has settled.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rects.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input dim_t val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < 6) dims[idx] = val;
  endtask

  task automatic write_dims(input dim_t rw, input dim_t rh, input dim_t fw,
                            input dim_t fh, input dim_t sw, input dim_t sh);
    write_reg(RegRenderedWidth, rw);
    write_reg(RegRenderedHeight, rh);
    write_reg(RegFirstRawWidth, fw);
    write_reg(RegFirstRawHeight, fh);
    write_reg(RegSecondRawWidth, sw);
    write_reg(RegSecondRawHeight, sh);
    @(posedge clk_i);
  endtask

  function automatic item_t query_item(input int fl, input int ft, input int sl, input int st);
    item_t it;
    it = '0;
    it.cmd = CmdQuery;
    it.first_left = coord_t'(fl);  it.first_top = coord_t'(ft);
    it.second_left = coord_t'(sl); it.second_top = coord_t'(st);
    return it;
  endfunction

  function automatic row_t make_row(input item_t it, input bit typed, input logic [1:0] oc,
                                    input int l, input int r, input int t, input int b);
    row_t row;
    row.it = it;
    row.typed = typed;
    row.res.outcome = oc;
    row.res.left = edge_t'(l);  row.res.right  = edge_t'(r);
    row.res.top  = edge_t'(t);  row.res.bottom = edge_t'(b);
    return row;
  endfunction

  // A random item: half are queries placed so the sprites come close, plus loads and noise.
  function automatic item_t random_item();
    item_t it;
    int rw, rh, bx, by;
    it = noise_item();
    rw = side_of(dims[0]);
    rh = side_of(dims[1]);
    case ($urandom_range(99)) inside
      [0:34]: begin
        it.cmd = $urandom_range(1) ? CmdLoadSecond : CmdLoadFirst;
        it.texel_index = 12'($urandom_range(FillTexels - 1));
        if ($urandom_range(1)) it.texel_alpha = '0;
      end
      [35:41]: it.cmd = CmdUnused;
      [42:49]: it.cmd = CmdQuery;
      default: begin
        bx = $urandom_range(8000) - 4000;
        by = $urandom_range(8000) - 4000;
        it.cmd = CmdQuery;
        it.first_left  = coord_t'(bx);
        it.first_top   = coord_t'(by);
        it.second_left = coord_t'(bx + $urandom_range(2 * rw + 2) - rw - 1);
        it.second_top  = coord_t'(by + $urandom_range(2 * rh + 2) - rh - 1);
      end
    endcase
    return it;
  endfunction

  // Receiver: random stalls, plus one long hold-off counted here once it is asked for.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_cnt_q   <= 0;
      hold_done_q  <= 1'b0;
    end else if (hold_req && !hold_done_q) begin
      out_ch.ready <= 1'b0;
      hold_cnt_q   <= hold_cnt_q + 1;
      if (hold_cnt_q == LongHold - 1) hold_done_q <= 1'b1;
    end else begin
      out_ch.ready <= !(recv_gaps && $urandom_range(99) < StallPct);
    end
  end

  // Result checker: each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      rect_t got, want;
      got = {out_ch.outcome, out_ch.overlap_left, out_ch.overlap_right,
             out_ch.overlap_top, out_ch.overlap_bottom};
      results_seen++;
      if (pending_rects.size() == 0) begin
        $display("%0t: unexpected result: outcome %0d rect %0d %0d %0d %0d", $time,
                 got.outcome, got.left, got.right, got.top, got.bottom);
        errors++;
      end else begin
        want = pending_rects.pop_front();
        if (got.outcome == OutcomeCollision) collisions_seen++;
        if (got !== want) begin
          $display("%0t: mismatch: expected %0d l%0d r%0d t%0d b%0d, got %0d l%0d r%0d t%0d b%0d",
                   $time, want.outcome, want.left, want.right, want.top, want.bottom,
                   got.outcome, got.left, got.right, got.top, got.bottom);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               pending_rects.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    row_t  table_rows[$];
    item_t it;
    rect_t none_rect;
    int    fw, fh, sw, sh;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdLoadFirst;
    in_ch.texel_index = '0;
    in_ch.texel_alpha = '0;
    in_ch.first_left = '0;
    in_ch.first_top = '0;
    in_ch.second_left = '0;
    in_ch.second_top = '0;
    queries_sent = 0;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
    none_rect = '0;
    foreach (dims[i]) dims[i] = DimReset;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The low texels of both masks are written first; every size used below keeps the
    // texel count of each sprite within them, so no query reads an unwritten texel.
    for (int i = 0; i < FillTexels; i++) begin
      for (int m = 0; m < 2; m++) begin
        it = noise_item();
        it.cmd = m ? CmdLoadSecond : CmdLoadFirst;
        it.texel_index = i[11:0];
        if ($urandom_range(1)) it.texel_alpha = '0;
        offer_item(it, 1'b0, none_rect);
      end
    end
    drain_block();
    write_dims(7'd32, 7'd32, 7'd8, 7'd4, 7'd4, 7'd8);

    // Directed rows at a rendered size of 32 by 32.
    table_rows.push_back(make_row(query_item(-4096, -4096, 4095, 4095), 1, OutcomeNone,
                                  0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(4095, -4096, -4096, 4095), 1, OutcomeNone,
                                  0, 0, 0, 0));
    // Touching edges give an empty rectangle and still count as an intersection.
    table_rows.push_back(make_row(query_item(0, 0, 32, 0), 1, OutcomeIntersect,
                                  32, 32, 0, 32));
    table_rows.push_back(make_row(query_item(10, -4096, 10, -4064), 1, OutcomeIntersect,
                                  10, 42, -4064, -4064));
    table_rows.push_back(make_row(query_item(0, 0, 33, 0), 1, OutcomeNone, 0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(0, 0, 0, 0), 0, OutcomeNone, 0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(4095, 4095, 4095, 4095), 0, OutcomeNone,
                                  0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(-4096, -4096, -4080, -4090), 0, OutcomeNone,
                                  0, 0, 0, 0));
    it = '1; it.cmd = CmdLoadFirst;
    table_rows.push_back(make_row(it, 0, OutcomeNone, 0, 0, 0, 0));
    it = '0; it.cmd = CmdLoadSecond; it.texel_alpha = 8'd1;
    table_rows.push_back(make_row(it, 0, OutcomeNone, 0, 0, 0, 0));
    it = '0; it.cmd = CmdLoadFirst; it.texel_alpha = 8'd128;
    table_rows.push_back(make_row(it, 0, OutcomeNone, 0, 0, 0, 0));
    it = '1; it.cmd = CmdLoadSecond; it.texel_alpha = '0;
    table_rows.push_back(make_row(it, 0, OutcomeNone, 0, 0, 0, 0));
    // An unknown command must not produce a result.
    it = '1; it.cmd = CmdUnused;
    table_rows.push_back(make_row(it, 0, OutcomeNone, 0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(5, 7, 20, -3), 0, OutcomeNone, 0, 0, 0, 0));
    table_rows.push_back(make_row(query_item(-31, 31, 0, 0), 0, OutcomeNone, 0, 0, 0, 0));
    foreach (table_rows[i]) offer_item(table_rows[i].it, table_rows[i].typed, table_rows[i].res);
    drain_block();

    // Random phases, each under its own sizes; the extremes and out-of-range values first.
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: write_dims(7'd64, 7'd64, 7'd32, 7'd1, 7'd1, 7'd32);
        1: write_dims(7'd1, 7'd1, 7'd1, 7'd1, 7'd1, 7'd1);
        2: begin
          // Zero is used as one and anything past the largest side as that side.
          write_dims(7'd0, 7'd127, 7'd0, 7'd0, 7'd0, 7'd0);
          write_reg(RegBeyond6, 7'd5);
          write_reg(RegBeyond7, 7'd9);
        end
        3: write_dims(7'd1, 7'd64, 7'd32, 7'd1, 7'd1, 7'd32);
        default: begin
          fw = $urandom_range(1, FillTexels);
          fh = $urandom_range(1, FillTexels / fw);
          sw = $urandom_range(1, FillTexels);
          sh = $urandom_range(1, FillTexels / sw);
          write_dims(dim_t'($urandom_range(1, 16)), dim_t'($urandom_range(1, 16)),
                     dim_t'(fw), dim_t'(fh), dim_t'(sw), dim_t'(sh));
        end
      endcase
      // One phase runs without random stalls on either side.
      send_gaps = (phase != 4);
      recv_gaps = (phase != 4);
      // In another the receiver holds off while items keep coming, so the block backs up.
      if (phase == 5) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        offer_item(random_item(), 1'b0, none_rect);
        // Halfway through, the sender waits for every outstanding result.
        if (n == PhaseItems / 2) drain_block();
      end
      drain_block();
    end

    $display("Covered %0d queries and %0d results, %0d of them pixel collisions,",
             queries_sent, results_seen, collisions_seen);
    $display("across seven size settings with stalls, a long hold-off and errors %0d.", errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sprite_pixel_collision_top.f
hw/rtl/spc_pkg.sv
hw/rtl/spc_in_if.sv
hw/rtl/spc_out_if.sv
hw/rtl/sprite_pixel_collision_top.sv
test/sprite_pixel_collision_top_tb.sv
